[design/adts_pkg.sv]
// Shared types and constants for the ADTS frame splitter.
`timescale 1ns / 1ps

package adts_pkg;

    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE     = 4'hF;
    localparam logic [2:0]  HDR_FIRST_IDX   = 3'd2;
    localparam logic [2:0]  HDR_LAST_IDX    = 3'd6;
    localparam logic [12:0] HDR_BYTES       = 13'd7;
    localparam logic [12:0] MIN_FRAME_RESET = 13'd32;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HEAD = 3'b010,
        PH_SKIP = 3'b100
    } t_phase;

    typedef struct packed {
        logic [12:0] frame_length;
        logic        mpeg_id;
        logic [1:0]  layer_bits;
        logic        crc_absent;
        logic [1:0]  profile_code;
        logic [3:0]  rate_index;
        logic [2:0]  channel_code;
        logic [10:0] fullness;
        logic [1:0]  raw_blocks;
        logic        long_enough;
    } t_desc;

    // Header bytes 1..6, byte 1 in the top bits; long_enough is filled by the caller.
    function automatic t_desc hdr_decode(input logic [47:0] hdr);
        t_desc      d;
        logic [7:0] b1, b2, b3, b4, b5, b6;
        b1 = hdr[47:40];
        b2 = hdr[39:32];
        b3 = hdr[31:24];
        b4 = hdr[23:16];
        b5 = hdr[15:8];
        b6 = hdr[7:0];
        d.frame_length = {b3[1:0], b4, b5[7:5]};
        d.mpeg_id      = b1[3];
        d.layer_bits   = b1[2:1];
        d.crc_absent   = b1[0];
        d.profile_code = b2[7:6];
        d.rate_index   = b2[5:2];
        d.channel_code = {b2[0], b3[7:6]};
        d.fullness     = {b5[4:0], b6[7:2]};
        d.raw_blocks   = b6[1:0];
        d.long_enough  = 1'b0;
        return d;
    endfunction

endpackage

[design/adts_core.sv]
// Sync hunt, header gather and payload skip state machine.
`timescale 1ns / 1ps

module adts_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  logic [12:0]   i_min_len,
    output logic          o_emit,
    output adts_pkg::t_desc o_desc
);
    import adts_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [2:0]  r_idx, n_idx;
    logic [39:0] r_hdr, n_hdr;
    logic [12:0] r_skip, n_skip;

    t_desc       dec;
    logic        emit;

    always_comb begin
        dec = hdr_decode({r_hdr, i_byte});
        dec.long_enough = (dec.frame_length >= i_min_len);
    end

    always_comb begin
        n_phase = r_phase;
        n_prev  = r_prev;
        n_idx   = r_idx;
        n_hdr   = r_hdr;
        n_skip  = r_skip;
        emit    = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                n_hdr = {r_hdr[31:0], i_byte};
                if (r_idx >= HDR_LAST_IDX) begin
                    emit = 1'b1;
                    if (dec.frame_length > HDR_BYTES) begin
                        n_phase = PH_SKIP;
                        n_skip  = dec.frame_length - HDR_BYTES;
                        n_idx   = 3'd0;
                    end else begin
                        n_phase = PH_HUNT;
                        n_prev  = 8'd0;
                        n_idx   = 3'd0;
                        n_skip  = 13'd0;
                    end
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            PH_SKIP: begin
                if (r_skip <= 13'd1) begin
                    n_phase = PH_HUNT;
                    n_prev  = 8'd0;
                    n_idx   = 3'd0;
                    n_skip  = 13'd0;
                end else begin
                    n_skip = r_skip - 13'd1;
                end
            end
            default: begin
                if (r_prev == SYNC_BYTE && i_byte[7:4] == SYNC_NIBBLE) begin
                    n_phase = PH_HEAD;
                    n_hdr   = {32'd0, i_byte};
                    n_idx   = HDR_FIRST_IDX;
                    n_prev  = 8'd0;
                end else begin
                    n_phase = PH_HUNT;
                    n_prev  = i_byte;
                end
            end
        endcase
        // end of buffer: no sync pair spans two buffers
        if (i_last) begin
            n_phase = PH_HUNT;
            n_prev  = 8'd0;
            n_idx   = 3'd0;
            n_skip  = 13'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prev  <= 8'd0;
            r_idx   <= 3'd0;
            r_skip  <= 13'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_idx   <= n_idx;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_emit = emit;
    assign o_desc = dec;

endmodule

[design/adts_frame_splitter.sv]
// Top level of the ADTS frame splitter: handshakes, config register, result register.
`timescale 1ns / 1ps

// Takes one byte per clock while o_in_stall is low. Each item passes an input register and
// then the parser state machine, whose descriptor lands in the result register once the
// seventh header byte has passed the input register and the parser. The
// single-cycle state update in adts_core sets the rate of one item per cycle;
// o_in_stall rises only when both registers are full and the output is stalled.
module adts_frame_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_frame_length,
    output logic        o_mpeg_id,
    output logic [1:0]  o_layer_bits,
    output logic        o_crc_absent,
    output logic [1:0]  o_profile_code,
    output logic [3:0]  o_rate_index,
    output logic [2:0]  o_channel_code,
    output logic [10:0] o_fullness,
    output logic [1:0]  o_raw_blocks,
    output logic        o_long_enough
);
    import adts_pkg::*;

    logic [12:0] r_min_len;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_desc       r_desc;

    logic        out_free;
    logic        fire;
    logic        emit;
    t_desc       desc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_FRAME_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_buffer_end;
        end
    end

    adts_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_min_len (r_min_len),
        .o_emit    (emit),
        .o_desc    (desc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_desc <= desc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_length = r_desc.frame_length;
    assign o_mpeg_id      = r_desc.mpeg_id;
    assign o_layer_bits   = r_desc.layer_bits;
    assign o_crc_absent   = r_desc.crc_absent;
    assign o_profile_code = r_desc.profile_code;
    assign o_rate_index   = r_desc.rate_index;
    assign o_channel_code = r_desc.channel_code;
    assign o_fullness     = r_desc.fullness;
    assign o_raw_blocks   = r_desc.raw_blocks;
    assign o_long_enough  = r_desc.long_enough;

endmodule

[test/tb_adts_frame_splitter.sv]
// Testbench for the ADTS frame splitter: directed header table, then random byte streams.
`timescale 1ns / 1ps

module tb_adts_frame_splitter;
    import adts_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_desc      want;
    } t_stim_row;

    localparam t_desc DESC_ZERO = '0;
    localparam t_desc DESC_ONES = '1;

    localparam logic [12:0] MIN_LEN_CORNERS [4] = '{13'd0, 13'h1FFF, 13'd8, 13'd7};

    localparam t_stim_row DIRECTED [26] = '{
        // all-zero header, length below 7
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hF0, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b1, DESC_ZERO},
        // all-ones header, longest frame, cut by buffer end
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b1, DESC_ONES},
        '{8'h00, 1'b1, 1'b0, DESC_ZERO},
        // sync pair split by buffer end
        '{8'hFF, 1'b1, 1'b0, DESC_ZERO},
        '{8'hF3, 1'b0, 1'b0, DESC_ZERO},
        // length 8: one payload byte, then no sync across the frame end
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hF9, 1'b0, 1'b0, DESC_ZERO},
        '{8'h80, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h01, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'h00, 1'b0, 1'b0, DESC_ZERO},
        '{8'hFF, 1'b0, 1'b0, DESC_ZERO},
        '{8'hF0, 1'b0, 1'b0, DESC_ZERO}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [12:0] i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_buffer_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [12:0] o_frame_length;
    logic        o_mpeg_id;
    logic [1:0]  o_layer_bits;
    logic        o_crc_absent;
    logic [1:0]  o_profile_code;
    logic [3:0]  o_rate_index;
    logic [2:0]  o_channel_code;
    logic [10:0] o_fullness;
    logic [1:0]  o_raw_blocks;
    logic        o_long_enough;

    // parser shadow state
    t_phase      ph;
    logic [7:0]  last_seen;
    logic [2:0]  hdr_count;
    logic [47:0] hdr_shift;
    logic [12:0] skip_left;
    logic [12:0] min_len;

    t_desc       desc_expected [$];
    t_stim_row   stim_q [$];
    logic        row_typed;
    t_desc       row_want;
    int          mismatches;
    bit          src_quiet  = 1'b0;
    bit          sink_quiet = 1'b0;

    adts_frame_splitter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_buffer_end   (i_buffer_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_length (o_frame_length),
        .o_mpeg_id      (o_mpeg_id),
        .o_layer_bits   (o_layer_bits),
        .o_crc_absent   (o_crc_absent),
        .o_profile_code (o_profile_code),
        .o_rate_index   (o_rate_index),
        .o_channel_code (o_channel_code),
        .o_fullness     (o_fullness),
        .o_raw_blocks   (o_raw_blocks),
        .o_long_enough  (o_long_enough)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic resync();
        ph        = PH_HUNT;
        last_seen = 8'h00;
        hdr_count = 3'd0;
        hdr_shift = 48'd0;
        skip_left = 13'd0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last,
                              output logic hit, output t_desc d);
        logic [7:0] b1, b2, b3, b4, b5, b6;
        hit = 1'b0;
        d   = '0;
        case (ph)
            PH_HEAD: begin
                hdr_shift = {hdr_shift[39:0], b};
                if (hdr_count >= HDR_LAST_IDX) begin
                    {b1, b2, b3, b4, b5, b6} = hdr_shift;
                    d.frame_length = {b3[1:0], b4, b5[7:5]};
                    d.mpeg_id      = b1[3];
                    d.layer_bits   = b1[2:1];
                    d.crc_absent   = b1[0];
                    d.profile_code = b2[7:6];
                    d.rate_index   = b2[5:2];
                    d.channel_code = {b2[0], b3[7:6]};
                    d.fullness     = {b5[4:0], b6[7:2]};
                    d.raw_blocks   = b6[1:0];
                    d.long_enough  = d.frame_length >= min_len;
                    hit = 1'b1;
                    if (d.frame_length > HDR_BYTES) begin
                        ph        = PH_SKIP;
                        skip_left = d.frame_length - HDR_BYTES;
                        hdr_count = 3'd0;
                    end else begin
                        resync();
                    end
                end else begin
                    hdr_count = hdr_count + 3'd1;
                end
            end
            PH_SKIP: begin
                if (skip_left <= 13'd1) begin
                    resync();
                end else begin
                    skip_left = skip_left - 13'd1;
                end
            end
            default: begin
                if (last_seen == SYNC_BYTE && b[7:4] == SYNC_NIBBLE) begin
                    ph        = PH_HEAD;
                    hdr_shift = {40'd0, b};
                    hdr_count = HDR_FIRST_IDX;
                    last_seen = 8'h00;
                end else begin
                    ph        = PH_HUNT;
                    last_seen = b;
                end
            end
        endcase
        if (last) begin
            resync();
        end
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        logic  hit;
        t_desc d;
        t_desc seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_buffer_end, hit, d);
                if (hit) begin
                    desc_expected.push_back(row_typed ? row_want : d);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                seen = {o_frame_length, o_mpeg_id, o_layer_bits, o_crc_absent,
                        o_profile_code, o_rate_index, o_channel_code, o_fullness,
                        o_raw_blocks, o_long_enough};
                if (desc_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected descriptor: %h", seen);
                    end
                end else begin
                    d = desc_expected.pop_front();
                    check_field("frame_length", d.frame_length, seen.frame_length);
                    check_field("mpeg_id", 13'(d.mpeg_id), 13'(seen.mpeg_id));
                    check_field("layer_bits", 13'(d.layer_bits), 13'(seen.layer_bits));
                    check_field("crc_absent", 13'(d.crc_absent), 13'(seen.crc_absent));
                    check_field("profile_code", 13'(d.profile_code),
                                13'(seen.profile_code));
                    check_field("rate_index", 13'(d.rate_index), 13'(seen.rate_index));
                    check_field("channel_code", 13'(d.channel_code),
                                13'(seen.channel_code));
                    check_field("fullness", 13'(d.fullness), 13'(seen.fullness));
                    check_field("raw_blocks", 13'(d.raw_blocks), 13'(seen.raw_blocks));
                    check_field("long_enough", 13'(d.long_enough),
                                13'(seen.long_enough));
                end
            end
        end
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    task automatic send_row(input t_stim_row r);
        repeat (pick_gap(src_quiet)) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_data_byte  = r.data;
        i_buffer_end = r.last;
        row_typed    = r.typed;
        row_want     = r.want;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (desc_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_min_len(input logic [12:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        min_len     = v;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        stim_q.push_back('{b, last, 1'b0, DESC_ZERO});
    endtask

    // One random frame: mostly well formed, some noise and cut-off headers.
    task automatic add_frame();
        int          kind;
        int          r;
        int          cut;
        int          npay;
        bit          ends_buffer;
        logic [12:0] len;
        logic [7:0]  seq [7];
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 6)) begin
                push_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom),
                          $urandom_range(0, 29) == 0);
            end
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
            len = 13'($urandom_range(0, 7));
        end else if (r < 80) begin
            len = 13'($urandom_range(8, 28));
        end else if (r < 92) begin
            len = 13'($urandom_range(29, 70));
        end else begin
            len = 13'($urandom);
        end
        seq[0] = SYNC_BYTE;
        seq[1] = {SYNC_NIBBLE, 4'($urandom)};
        seq[2] = 8'($urandom);
        seq[3] = {6'($urandom), len[12:11]};
        seq[4] = len[10:3];
        seq[5] = {len[2:0], 5'($urandom)};
        seq[6] = 8'($urandom);
        if (kind < 22) begin
            cut = $urandom_range(1, 6);
            for (int i = 0; i <= cut; i++) begin
                push_byte(seq[i], i == cut);
            end
            return;
        end
        npay        = (len > HDR_BYTES) ? int'(len) - 7 : 0;
        ends_buffer = (len > 13'd70) || ($urandom_range(0, 7) == 0);
        cut         = (len > 13'd70) ? $urandom_range(0, 20) : npay;
        for (int i = 0; i < 7; i++) begin
            push_byte(seq[i], ends_buffer && cut == 0 && i == 6);
        end
        for (int i = 0; i < cut; i++) begin
            push_byte(8'($urandom), ends_buffer && i == cut - 1);
        end
    endtask

    initial begin : sink
        int hold;
        int r;
        i_out_stall = 1'b0;
        hold        = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (sink_quiet || r < 55) begin
                    i_out_stall = 1'b0;
                    hold        = $urandom_range(0, 12);
                end else if (r < 93) begin
                    i_out_stall = 1'b1;
                    hold        = $urandom_range(0, 3);
                end else begin
                    i_out_stall = 1'b1;
                    hold        = $urandom_range(8, 40);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 13'd0;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_buffer_end  = 1'b0;
        row_typed     = 1'b0;
        row_want      = DESC_ZERO;
        mismatches    = 0;
        min_len       = MIN_FRAME_RESET;
        resync();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[k]) begin
            send_row(DIRECTED[k]);
        end
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_min_len((p < 4) ? MIN_LEN_CORNERS[p] : 13'($urandom));
            src_quiet  = (p == 2);
            sink_quiet = (p == 2);
            stim_q.delete();
            while (stim_q.size() < ITEMS_PER_PHASE) begin
                add_frame();
            end
            foreach (stim_q[k]) begin
                send_row(stim_q[k]);
            end
            src_quiet  = 1'b0;
            sink_quiet = 1'b0;
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
